// ----- design/acrms_pkg.sv -----
// Shared types and constants of the AC RMS voltage meter.
package acrms_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int RMS_W      = 20;
  localparam int VOLTS_W    = 32;
  localparam int SPW_W      = 16;
  localparam int WTA_W      = 8;
  localparam int VPC_W      = 32;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOWS_TO_AVERAGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTS_PER_COUNT_Q16 = 2'd2;

  localparam logic [SPW_W-1:0] SPW_RESET = 16'd1000;
  localparam logic [WTA_W-1:0] WTA_RESET = 8'd1;
  localparam logic [VPC_W-1:0] VPC_RESET = 32'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_DIV,
    ST_SQUARE,
    ST_SQ_DIV,
    ST_ROOT,
    ST_AVG_DIV,
    ST_SCALE,
    ST_PUSH
  } state_t;

endpackage

// ----- design/acrms_in_if.sv -----
// Sample input channel: valid, ready and one ADC sample.
interface acrms_in_if;
  logic                          valid;
  logic                          ready;
  logic [acrms_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// ----- design/acrms_out_if.sv -----
// Result channel: valid, ready and one measurement word.
interface acrms_out_if;
  logic                           valid;
  logic                           ready;
  logic [acrms_pkg::SAMPLE_W-1:0] last_sample;
  logic [acrms_pkg::SAMPLE_W-1:0] zero_offset;
  logic [acrms_pkg::RMS_W-1:0]    rms_counts_q8;
  logic [acrms_pkg::VOLTS_W-1:0]  rms_volts_q16;

  modport source (output valid, output last_sample, output zero_offset,
                  output rms_counts_q8, output rms_volts_q16, input ready);
  modport sink   (input valid, input last_sample, input zero_offset,
                  input rms_counts_q8, input rms_volts_q16, output ready);
endinterface

// ----- design/acrms_cfg_if.sv -----
// Register write channel: valid, ready, register index and write data.
interface acrms_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [acrms_pkg::CFG_IDX_W-1:0]  index;
  logic [acrms_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/acrms_div.sv -----
// Restoring divider, one quotient bit per cycle.
module acrms_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   rsh;
  logic [DVS_W:0]   sub;
  logic             ge;

  assign rsh = {rem_r, dq_r[DVD_W-1]};
  assign sub = rsh - {1'b0, dvs_r};
  assign ge  = rsh >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = CNT_W'(DVD_W);
      dq_nxt  = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      dq_nxt  = {dq_r[DVD_W-2:0], ge};
      rem_nxt = ge ? sub[DVS_W-1:0] : rsh[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = cnt_r != '0;
  assign quotient = dq_r;

endmodule

// ----- design/acrms_sqrt.sv -----
// Integer square root, one root bit per cycle from two radicand bits.
module acrms_sqrt #(
  parameter int RAD_W = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RAD_W-1:0]   radicand,
  output logic               busy,
  output logic [RAD_W/2-1:0] root
);

  localparam int RT_W  = RAD_W / 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [RT_W+1:0]  rem_r, rem_nxt;
  logic [RT_W-1:0]  root_r, root_nxt;
  logic [RT_W+2:0]  rsh;
  logic [RT_W+2:0]  trial;
  logic [RT_W+2:0]  diff;
  logic             ge;

  assign rsh   = {rem_r[RT_W:0], rad_r[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign diff  = rsh - trial;
  assign ge    = rsh >= trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      cnt_nxt  = CNT_W'(RT_W);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = ge ? diff[RT_W+1:0] : rsh[RT_W+1:0];
      root_nxt = {root_r[RT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = cnt_r != '0;
  assign root = root_r;

endmodule

// ----- design/ac_rms_voltage_meter.sv -----
// Top level of the AC RMS voltage meter with zero-point removal.
//
//   channel  dir  word                                                   handshake
//   in_ch    in   adc_sample                                             valid/ready
//   out_ch   out  last_sample, zero_offset, rms_counts_q8, rms_volts_q16 valid/ready
//   cfg_ch   in   index, data                                            valid/ready
//
// Mean-phase samples are accumulated directly. Square-phase samples pass through the
// bit-serial shift-add multiplier. The last sample of a phase adds a pass through the
// restoring divider; the last sample of a window adds the root unit; the last of a group
// adds another divide, a multiplier pass and the output load.
// Reset (synchronous, rst_n low) clears the control state and loads register defaults.
// A waiting result does not block input; a second result holds until out_ch is free.
module ac_rms_voltage_meter #(
  parameter int ADC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  acrms_in_if.sink     in_ch,
  acrms_out_if.source  out_ch,
  acrms_cfg_if.sink    cfg_ch
);

  localparam int S_W    = (ADC_BITS < acrms_pkg::SAMPLE_W) ? ADC_BITS : acrms_pkg::SAMPLE_W;
  localparam int MEAN_W = S_W + acrms_pkg::SPW_W;
  localparam int SQ_W   = 2 * S_W + acrms_pkg::SPW_W;
  localparam int RT_W   = S_W + acrms_pkg::FRAC_W;
  localparam int RACC_W = RT_W + acrms_pkg::WTA_W;
  localparam int PW     = acrms_pkg::VPC_W + RT_W;
  localparam int MCNT_W = $clog2(RT_W + 1);
  localparam int VSAT_B = acrms_pkg::VOLTS_W + acrms_pkg::FRAC_W;

  acrms_pkg::state_t state_r, state_nxt;

  logic                          phase_r, phase_nxt;
  logic [acrms_pkg::SPW_W-1:0]   cnt_r, cnt_nxt;
  logic [MEAN_W-1:0]             mean_acc_r, mean_acc_nxt;
  logic [S_W-1:0]                zp_r, zp_nxt;
  logic [SQ_W-1:0]               sq_acc_r, sq_acc_nxt;
  logic [RACC_W-1:0]             root_acc_r, root_acc_nxt;
  logic [acrms_pkg::WTA_W-1:0]   win_r, win_nxt;
  logic [S_W-1:0]                latest_r, latest_nxt;
  logic [acrms_pkg::SPW_W-1:0]   spw_r, spw_nxt;
  logic [acrms_pkg::WTA_W-1:0]   wta_r, wta_nxt;
  logic [acrms_pkg::VPC_W-1:0]   vpc_r, vpc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [MCNT_W-1:0]             mcnt_r, mcnt_nxt;

  logic [RT_W-1:0]               avg_r, avg_nxt;
  logic [acrms_pkg::VPC_W-1:0]   mcand_r, mcand_nxt;
  logic [PW-1:0]                 prod_r, prod_nxt;
  logic [acrms_pkg::SAMPLE_W-1:0] out_last_r, out_last_nxt;
  logic [acrms_pkg::SAMPLE_W-1:0] out_zero_r, out_zero_nxt;
  logic [acrms_pkg::RMS_W-1:0]   out_rms_r, out_rms_nxt;
  logic [acrms_pkg::VOLTS_W-1:0] out_volts_r, out_volts_nxt;

  logic                          div_start;
  logic [SQ_W-1:0]               div_dvd;
  logic [acrms_pkg::SPW_W-1:0]   div_dvs;
  logic                          div_busy;
  logic [SQ_W-1:0]               div_q;
  logic                          sqrt_start;
  logic                          sqrt_busy;
  logic [RT_W-1:0]               sqrt_root;

  logic                          mul_load;
  logic [acrms_pkg::VPC_W-1:0]   mul_x;
  logic [RT_W-1:0]               mul_y;
  logic [acrms_pkg::VPC_W:0]     msum;

  logic                          in_acc;
  logic                          out_acc;
  logic [S_W-1:0]                smp;
  logic [S_W:0]                  diff;
  logic [S_W-1:0]                absd;
  logic [acrms_pkg::SPW_W-1:0]   n_eff;
  logic [acrms_pkg::WTA_W-1:0]   m_eff;
  logic [acrms_pkg::SPW_W-1:0]   cnt_inc;
  logic [MEAN_W-1:0]             macc_sum;
  logic [SQ_W-1:0]               sq_sum;
  logic [RACC_W-1:0]             racc_sum;
  logic [acrms_pkg::WTA_W-1:0]   win_inc;
  logic [acrms_pkg::VOLTS_W-1:0] volts;

  acrms_div #(
    .DVD_W (SQ_W),
    .DVS_W (acrms_pkg::SPW_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  acrms_sqrt #(
    .RAD_W (SQ_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({div_q[2*S_W-1:0], {(2*acrms_pkg::FRAC_W){1'b0}}}),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  assign in_ch.ready  = state_r == acrms_pkg::ST_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_valid_r && out_ch.ready;

  assign smp      = in_ch.adc_sample[S_W-1:0];
  assign diff     = {1'b0, smp} - {1'b0, zp_r};
  assign absd     = diff[S_W] ? S_W'(-diff) : diff[S_W-1:0];
  assign n_eff    = (spw_r == '0) ? acrms_pkg::SPW_W'(1) : spw_r;
  assign m_eff    = (wta_r == '0) ? acrms_pkg::WTA_W'(1) : wta_r;
  assign cnt_inc  = cnt_r + acrms_pkg::SPW_W'(1);
  assign macc_sum = mean_acc_r + MEAN_W'(smp);
  assign sq_sum   = sq_acc_r + SQ_W'(prod_r[2*S_W-1:0]);
  assign racc_sum = root_acc_r + RACC_W'(sqrt_root);
  assign win_inc  = win_r + acrms_pkg::WTA_W'(1);
  assign msum     = {1'b0, prod_r[PW-1:RT_W]}
                  + (prod_r[0] ? {1'b0, mcand_r} : {(acrms_pkg::VPC_W+1){1'b0}});
  assign volts    = (|prod_r[PW-1:VSAT_B]) ? '1 : prod_r[VSAT_B-1:acrms_pkg::FRAC_W];

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    mean_acc_nxt  = mean_acc_r;
    zp_nxt        = zp_r;
    sq_acc_nxt    = sq_acc_r;
    root_acc_nxt  = root_acc_r;
    win_nxt       = win_r;
    latest_nxt    = latest_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_zero_nxt  = out_zero_r;
    out_rms_nxt   = out_rms_r;
    out_volts_nxt = out_volts_r;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    sqrt_start    = 1'b0;
    mul_load      = 1'b0;
    mul_x         = '0;
    mul_y         = '0;

    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      acrms_pkg::ST_IDLE: begin
        if (in_acc) begin
          latest_nxt = smp;
          cnt_nxt    = cnt_inc;
          if (!phase_r) begin
            if (cnt_inc >= n_eff) begin
              div_start    = 1'b1;
              div_dvd      = SQ_W'(macc_sum);
              div_dvs      = cnt_inc;
              mean_acc_nxt = '0;
              state_nxt    = acrms_pkg::ST_MEAN_DIV;
            end else begin
              mean_acc_nxt = macc_sum;
            end
          end else begin
            mul_load  = 1'b1;
            mul_x     = acrms_pkg::VPC_W'(absd);
            mul_y     = RT_W'(absd);
            state_nxt = acrms_pkg::ST_SQUARE;
          end
        end
      end
      acrms_pkg::ST_MEAN_DIV: begin
        if (!div_busy) begin
          zp_nxt    = div_q[S_W-1:0];
          cnt_nxt   = '0;
          phase_nxt = 1'b1;
          state_nxt = acrms_pkg::ST_IDLE;
        end
      end
      acrms_pkg::ST_SQUARE: begin
        if (mcnt_r == '0) begin
          if (cnt_r < n_eff) begin
            sq_acc_nxt = sq_sum;
            state_nxt  = acrms_pkg::ST_IDLE;
          end else begin
            div_start  = 1'b1;
            div_dvd    = sq_sum;
            div_dvs    = cnt_r;
            sq_acc_nxt = '0;
            state_nxt  = acrms_pkg::ST_SQ_DIV;
          end
        end
      end
      acrms_pkg::ST_SQ_DIV: begin
        if (!div_busy) begin
          sqrt_start = 1'b1;
          state_nxt  = acrms_pkg::ST_ROOT;
        end
      end
      acrms_pkg::ST_ROOT: begin
        if (!sqrt_busy) begin
          cnt_nxt   = '0;
          phase_nxt = 1'b0;
          if (win_inc < m_eff) begin
            root_acc_nxt = racc_sum;
            win_nxt      = win_inc;
            state_nxt    = acrms_pkg::ST_IDLE;
          end else begin
            div_start    = 1'b1;
            div_dvd      = SQ_W'(racc_sum);
            div_dvs      = acrms_pkg::SPW_W'(win_inc);
            root_acc_nxt = '0;
            win_nxt      = '0;
            state_nxt    = acrms_pkg::ST_AVG_DIV;
          end
        end
      end
      acrms_pkg::ST_AVG_DIV: begin
        if (!div_busy) begin
          avg_nxt   = div_q[RT_W-1:0];
          mul_load  = 1'b1;
          mul_x     = vpc_r;
          mul_y     = div_q[RT_W-1:0];
          state_nxt = acrms_pkg::ST_SCALE;
        end
      end
      acrms_pkg::ST_SCALE: begin
        if (mcnt_r == '0) begin
          state_nxt = acrms_pkg::ST_PUSH;
        end
      end
      acrms_pkg::ST_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = acrms_pkg::SAMPLE_W'(latest_r);
          out_zero_nxt  = acrms_pkg::SAMPLE_W'(zp_r);
          out_rms_nxt   = acrms_pkg::RMS_W'(avg_r);
          out_volts_nxt = volts;
          state_nxt     = acrms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = acrms_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    mcnt_nxt  = mcnt_r;
    if (mul_load) begin
      mcand_nxt = mul_x;
      prod_nxt  = PW'(mul_y);
      mcnt_nxt  = MCNT_W'(RT_W);
    end else if (mcnt_r != '0) begin
      prod_nxt = {msum, prod_r[RT_W-1:1]};
      mcnt_nxt = mcnt_r - MCNT_W'(1);
    end
  end

  always_comb begin
    spw_nxt = spw_r;
    wta_nxt = wta_r;
    vpc_nxt = vpc_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        acrms_pkg::REG_SAMPLES_PER_WINDOW:  spw_nxt = cfg_ch.data[acrms_pkg::SPW_W-1:0];
        acrms_pkg::REG_WINDOWS_TO_AVERAGE:  wta_nxt = cfg_ch.data[acrms_pkg::WTA_W-1:0];
        acrms_pkg::REG_VOLTS_PER_COUNT_Q16: vpc_nxt = cfg_ch.data[acrms_pkg::VPC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acrms_pkg::ST_IDLE;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      mean_acc_r  <= '0;
      zp_r        <= '0;
      sq_acc_r    <= '0;
      root_acc_r  <= '0;
      win_r       <= '0;
      latest_r    <= '0;
      spw_r       <= acrms_pkg::SPW_RESET;
      wta_r       <= acrms_pkg::WTA_RESET;
      vpc_r       <= acrms_pkg::VPC_RESET;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      mean_acc_r  <= mean_acc_nxt;
      zp_r        <= zp_nxt;
      sq_acc_r    <= sq_acc_nxt;
      root_acc_r  <= root_acc_nxt;
      win_r       <= win_nxt;
      latest_r    <= latest_nxt;
      spw_r       <= spw_nxt;
      wta_r       <= wta_nxt;
      vpc_r       <= vpc_nxt;
      out_valid_r <= out_valid_nxt;
      mcnt_r      <= mcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_r       <= avg_nxt;
    mcand_r     <= mcand_nxt;
    prod_r      <= prod_nxt;
    out_last_r  <= out_last_nxt;
    out_zero_r  <= out_zero_nxt;
    out_rms_r   <= out_rms_nxt;
    out_volts_r <= out_volts_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.last_sample   = out_last_r;
  assign out_ch.zero_offset   = out_zero_r;
  assign out_ch.rms_counts_q8 = out_rms_r;
  assign out_ch.rms_volts_q16 = out_volts_r;

endmodule

// ----- verif/ac_rms_voltage_meter_tb.sv -----
// Self-checking testbench of the AC RMS voltage meter with its own measurement predictor.
module ac_rms_voltage_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 256;
  localparam int HOLD_CYCLES  = 3000;
  localparam int RANDOM_ITEMS = 1550;
  localparam logic [acrms_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [acrms_pkg::SAMPLE_W-1:0] last_sample;
    logic [acrms_pkg::SAMPLE_W-1:0] zero_offset;
    logic [acrms_pkg::RMS_W-1:0]    rms_counts_q8;
    logic [acrms_pkg::VOLTS_W-1:0]  rms_volts_q16;
  } meas_t;

  typedef enum int {DRAW_UNIFORM, DRAW_AROUND, DRAW_RAILS} draw_t;

  logic clk;
  logic rst_n;

  acrms_in_if  in_ch ();
  acrms_out_if out_ch ();
  acrms_cfg_if cfg_ch ();

  ac_rms_voltage_meter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [acrms_pkg::SAMPLE_W-1:0] pending_samples [$];
  meas_t                          expected_meas [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int SEND_IDLE [4]  = '{0, 80, 0, 36};
  int RECV_STALL [4] = '{0, 0, 80, 36};

  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  int errors        = 0;
  int samples_taken = 0;
  int results_seen  = 0;
  int settings_seen = 0;

  // predictor state
  logic [acrms_pkg::SPW_W-1:0]    spw_cfg = acrms_pkg::SPW_RESET;
  logic [acrms_pkg::WTA_W-1:0]    wta_cfg = acrms_pkg::WTA_RESET;
  logic [acrms_pkg::VPC_W-1:0]    vpc_cfg = acrms_pkg::VPC_RESET;
  logic                           square_phase = 1'b0;
  logic [15:0]                    smp_count = '0;
  logic [27:0]                    mean_sum = '0;
  logic [acrms_pkg::SAMPLE_W-1:0] zero_pt = '0;
  logic [39:0]                    square_sum = '0;
  logic [27:0]                    root_sum = '0;
  logic [7:0]                     win_count = '0;
  logic [acrms_pkg::SAMPLE_W-1:0] latest = '0;

  function automatic logic [acrms_pkg::RMS_W-1:0] root_q8(input logic [63:0] mean_sq);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] t;
    v = mean_sq << 16;
    r = '0;
    for (int b = acrms_pkg::RMS_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[acrms_pkg::RMS_W-1:0];
  endfunction

  function automatic bit meter_accept(input logic [acrms_pkg::SAMPLE_W-1:0] smp,
                                      output meas_t res);
    int          n;
    int          m;
    int          dev;
    logic [27:0] zq;
    logic [27:0] avg;
    logic [63:0] volts;
    n = (spw_cfg == 0) ? 1 : int'(spw_cfg);
    m = (wta_cfg == 0) ? 1 : int'(wta_cfg);
    res = '0;
    latest = smp;
    smp_count = smp_count + 16'd1;
    if (smp_count == 0) smp_count = 16'd1;
    if (!square_phase) begin
      mean_sum = mean_sum + 28'(smp);
      if (int'(smp_count) >= n) begin
        zq = mean_sum / smp_count;
        zero_pt = zq[acrms_pkg::SAMPLE_W-1:0];
        mean_sum = '0;
        smp_count = '0;
        square_phase = 1'b1;
      end
      return 1'b0;
    end
    dev = int'(smp) - int'(zero_pt);
    square_sum = square_sum + 40'(dev * dev);
    if (int'(smp_count) < n) return 1'b0;
    root_sum = root_sum + 28'(root_q8(64'(square_sum / smp_count)));
    square_sum = '0;
    smp_count = '0;
    square_phase = 1'b0;
    win_count = win_count + 8'd1;
    if (win_count == 0) win_count = 8'd1;
    if (int'(win_count) < m) return 1'b0;
    avg = root_sum / win_count;
    if (avg > 28'hFFFFF) avg = 28'hFFFFF;
    volts = (64'(avg) * 64'(vpc_cfg)) >> acrms_pkg::FRAC_W;
    if (volts > 64'hFFFF_FFFF) volts = 64'hFFFF_FFFF;
    res.last_sample   = latest;
    res.zero_offset   = zero_pt;
    res.rms_counts_q8 = avg[acrms_pkg::RMS_W-1:0];
    res.rms_volts_q16 = volts[acrms_pkg::VOLTS_W-1:0];
    root_sum = '0;
    win_count = '0;
    return 1'b1;
  endfunction

  function automatic logic [acrms_pkg::SAMPLE_W-1:0] draw_sample(input draw_t style,
                                                                 input int centre,
                                                                 input int swing);
    int v;
    case (style)
      DRAW_AROUND: begin
        v = centre + int'($urandom_range(2 * swing)) - swing;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      DRAW_RAILS: begin
        v = $urandom_range(1) ? 4095 - int'($urandom_range(3)) : int'($urandom_range(3));
      end
      default: begin
        v = $urandom_range(4095);
      end
    endcase
    return v[acrms_pkg::SAMPLE_W-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sample driver
  always @(posedge clk) begin
    meas_t m;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.adc_sample <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        samples_taken++;
        if (meter_accept(in_ch.adc_sample, m)) expected_meas.push_back(m);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.adc_sample <= pending_samples.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    meas_t got;
    meas_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got.last_sample   = out_ch.last_sample;
        got.zero_offset   = out_ch.zero_offset;
        got.rms_counts_q8 = out_ch.rms_counts_q8;
        got.rms_volts_q16 = out_ch.rms_volts_q16;
        if (expected_meas.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: last=%0d zero=%0d rms=%0d volts=%0d", $time,
                   got.last_sample, got.zero_offset, got.rms_counts_q8, got.rms_volts_q16);
        end else begin
          want = expected_meas.pop_front();
          if (got.last_sample !== want.last_sample || got.zero_offset !== want.zero_offset ||
              got.rms_counts_q8 !== want.rms_counts_q8 ||
              got.rms_volts_q16 !== want.rms_volts_q16) begin
            errors++;
            $display("%0t: expected last=%0d zero=%0d rms=%0d volts=%0d", $time,
                     want.last_sample, want.zero_offset, want.rms_counts_q8,
                     want.rms_volts_q16);
            $display("%0t: actual   last=%0d zero=%0d rms=%0d volts=%0d", $time,
                     got.last_sample, got.zero_offset, got.rms_counts_q8, got.rms_volts_q16);
          end
        end
      end
      out_ch.ready <= !(hold_req && !hold_done) &&
                      (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_req);
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_done <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic program_meter(input logic [acrms_pkg::SPW_W-1:0] spw,
                               input logic [acrms_pkg::WTA_W-1:0] wta,
                               input logic [acrms_pkg::VPC_W-1:0] vpc);
    logic [acrms_pkg::CFG_IDX_W-1:0]  regs [4];
    logic [acrms_pkg::CFG_DATA_W-1:0] vals [4];
    regs = '{acrms_pkg::REG_SAMPLES_PER_WINDOW, acrms_pkg::REG_WINDOWS_TO_AVERAGE,
             acrms_pkg::REG_VOLTS_PER_COUNT_Q16, REG_UNMAPPED};
    vals = '{acrms_pkg::CFG_DATA_W'(spw), acrms_pkg::CFG_DATA_W'(wta),
             acrms_pkg::CFG_DATA_W'(vpc), acrms_pkg::CFG_DATA_W'($urandom)};
    settings_seen++;
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (regs[i])
        acrms_pkg::REG_SAMPLES_PER_WINDOW:  spw_cfg = vals[i][acrms_pkg::SPW_W-1:0];
        acrms_pkg::REG_WINDOWS_TO_AVERAGE:  wta_cfg = vals[i][acrms_pkg::WTA_W-1:0];
        acrms_pkg::REG_VOLTS_PER_COUNT_Q16: vpc_cfg = vals[i][acrms_pkg::VPC_W-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_ch.valid || expected_meas.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_samples(input int count);
    draw_t style;
    int    centre;
    int    swing;
    style  = draw_t'($urandom_range(2));
    centre = $urandom_range(4095);
    swing  = $urandom_range(1, 2047);
    for (int i = 0; i < count; i++) pending_samples.push_back(draw_sample(style, centre, swing));
  endtask

  task automatic pick_idling(input int k);
    send_idle_pct  = SEND_IDLE[k % 4];
    recv_stall_pct = RECV_STALL[k % 4];
  endtask

  initial begin
    logic [acrms_pkg::SPW_W-1:0] spw;
    logic [acrms_pkg::WTA_W-1:0] wta;
    logic [acrms_pkg::VPC_W-1:0] vpc;
    int pick;
    int n_eff;
    int m_eff;
    int count;
    int phase_no;
    int random_queued;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.adc_sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero counts act as one; full-scale deviation both ways; zero scale
    program_meter(16'd0, 8'd0, 32'd0);
    pending_samples = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'hAAA, 12'h555};
    wait_idle();
    // no deviation, then saturating scale
    program_meter(16'd1, 8'd1, 32'hFFFF_FFFF);
    pending_samples = '{12'd2048, 12'd2048, 12'd0, 12'd4095};
    wait_idle();
    // lower the sample count mid-phase, then the window count mid-group
    program_meter(16'hFFFF, 8'd3, acrms_pkg::VPC_RESET);
    queue_samples(5);
    wait_idle();
    program_meter(16'd2, 8'd3, acrms_pkg::VPC_RESET);
    queue_samples(7);
    wait_idle();
    program_meter(16'd2, 8'd1, 32'h0001_8000);
    queue_samples(4);
    wait_idle();

    phase_no = 0;
    random_queued = 0;

    // deepest window count in one group
    pick_idling(phase_no++);
    program_meter(16'd1, 8'd255, $urandom);
    queue_samples(510);
    random_queued += 510;
    wait_idle();

    // receiver holds off while the sender keeps offering words
    send_idle_pct = 0;
    recv_stall_pct = 0;
    program_meter(16'd1, 8'd1, $urandom);
    hold_req <= 1'b1;
    queue_samples(80);
    random_queued += 80;
    wait_idle();

    while (random_queued < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      spw = (pick < 5) ? 16'd0 : (pick < 80) ? 16'($urandom_range(1, 6)) :
            (pick < 95) ? 16'($urandom_range(7, 24)) : 16'($urandom_range(25, 64));
      pick = $urandom_range(99);
      wta = (pick < 5) ? 8'd0 : (pick < 85) ? 8'($urandom_range(1, 3)) :
            8'($urandom_range(4, 8));
      pick = $urandom_range(99);
      vpc = (pick < 10) ? 32'd0 : (pick < 20) ? 32'hFFFF_FFFF :
            (pick < 30) ? acrms_pkg::VPC_RESET : 32'($urandom);
      n_eff = (spw == 0) ? 1 : int'(spw);
      m_eff = (wta == 0) ? 1 : int'(wta);
      if (n_eff * m_eff > 96) begin
        wta = 8'd1;
        m_eff = 1;
      end
      count = 2 * n_eff * m_eff * int'($urandom_range(1, 3));
      if ($urandom_range(9) == 0) count += $urandom_range(1, 2 * n_eff);
      pick_idling(phase_no++);
      program_meter(spw, wta, vpc);
      queue_samples(count);
      random_queued += count;
      wait_idle();
    end

    $display("Fed %0d samples under %0d register settings, checked %0d measurements.",
             samples_taken, settings_seen, results_seen);
    $display("Mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/acrms_pkg.sv
design/acrms_in_if.sv
design/acrms_out_if.sv
design/acrms_cfg_if.sv
design/acrms_div.sv
design/acrms_sqrt.sv
design/ac_rms_voltage_meter.sv
verif/ac_rms_voltage_meter_tb.sv
